// ----- rtl/dsp2_pkg.sv -----
package dsp2_pkg;

	localparam int FracW = 52;
	localparam int ExpW  = 11;
	localparam int ManW  = 53;
	localparam int LzW   = 6;
	// exponent math width: covers 32-bit scale plus biased exponent
	localparam int XW    = 34;
	localparam logic [ExpW-1:0] ExpMax = 11'h7FF;

	// Per-item classification carried down the pipe.
	typedef struct packed {
		logic pass;	// NaN, infinity or zero: output equals operand
		logic sign;
	} cls_t;

	// Leading-zero count of a 53-bit mantissa (result 0..52).
	function automatic logic [LzW-1:0] lzc53(input logic [ManW-1:0] m);
		logic [LzW-1:0] r;
		logic           found;
		r = '0;
		found = 1'b0;
		for (int i = ManW - 1; i >= 0; i--) begin
			if (!found && m[i]) begin
				r = LzW'(ManW - 1 - i);
				found = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/dsp2_norm.sv -----
// Stage 1: classify, find leading zeros of the mantissa, add the scale to the exponent.
module dsp2_norm
	import dsp2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  logic [63:0]       x,
	input  logic signed [31:0] n,
	output logic              v_s1,
	output cls_t              cls_s1,
	output logic [63:0]       x_s1,
	output logic [ManW-1:0]   man_s1,
	output logic [LzW-1:0]    lz_s1,
	output logic signed [XW-1:0] ex_s1
);
	logic [ExpW-1:0] bexp;
	logic [ManW-1:0] man;
	logic [XW-1:0]   e0;

	always_comb begin
		bexp = x[62:52];
		man  = {bexp != '0, x[FracW-1:0]};
		// subnormal acts as exponent 1
		e0   = (bexp == '0) ? XW'(1) : XW'(bexp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1.pass <= (bexp == ExpMax) || (x[62:0] == '0);
			cls_s1.sign <= x[63];
			x_s1        <= x;
			man_s1      <= man;
			lz_s1       <= lzc53(man);
			ex_s1       <= $signed(e0) + XW'(n);
		end
	end
endmodule

// ----- rtl/dsp2_shift.sv -----
// Stage 2: normalize mantissa, final exponent.
module dsp2_shift
	import dsp2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_s1,
	input  cls_t              cls_s1,
	input  logic [63:0]       x_s1,
	input  logic [ManW-1:0]   man_s1,
	input  logic [LzW-1:0]    lz_s1,
	input  logic signed [XW-1:0] ex_s1,
	output logic              v_s2,
	output cls_t              cls_s2,
	output logic [63:0]       x_s2,
	output logic [ManW-1:0]   man_s2,
	output logic signed [XW-1:0] ex_s2
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s2 <= cls_s1;
			x_s2   <= x_s1;
			man_s2 <= man_s1 << lz_s1;
			ex_s2  <= ex_s1 - XW'(lz_s1);
		end
	end
endmodule

// ----- rtl/dsp2_round.sv -----
// Stage 3: pass special operands through, pack normal, overflow, or denormalize with RNE.
module dsp2_round
	import dsp2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_s2,
	input  cls_t              cls_s2,
	input  logic [63:0]       x_s2,
	input  logic [ManW-1:0]   man_s2,
	input  logic signed [XW-1:0] ex_s2,
	output logic              v_s3,
	output logic [63:0]       r_s3
);
	logic [XW-1:0]   sh;
	logic [5:0]      s;
	logic [ManW+1:0] ext;	// mantissa, guard, sticky-free extended
	logic [ManW+1:0] shv;
	logic [ManW+1:0] lost;
	logic [ManW-1:0] q;
	logic            g, st;
	logic [63:0]     r;

	always_comb begin
		sh   = XW'(1) - ex_s2;
		s    = (sh > XW'(54)) ? 6'd55 : sh[5:0];
		ext  = {1'b0, man_s2, 1'b0};
		shv  = ext >> s;
		lost = ext & ~(({(ManW+2){1'b1}}) << s);
		q    = shv[ManW:1];
		g    = shv[0];
		st   = lost != '0;
		if (cls_s2.pass) begin
			r = x_s2;
		end else if (ex_s2 >= $signed(XW'(ExpMax))) begin
			r = {cls_s2.sign, ExpMax, {FracW{1'b0}}};
		end else if (ex_s2 >= $signed(XW'(1))) begin
			r = {cls_s2.sign, ex_s2[ExpW-1:0], man_s2[FracW-1:0]};
		end else if (sh > XW'(54)) begin
			r = {cls_s2.sign, 63'd0};
		end else begin
			r = {cls_s2.sign, 10'd0, q + ManW'(g && (st || q[0]))};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r;
		end
	end
endmodule

// ----- rtl/double_scale_by_power_of_two.sv -----
// Binary64 scale by a power of two (ldexp).
// s_axis: tdata = {scale_exponent[95:64], operand_bits[63:0]}; transfer on tvalid & tready.
// m_axis: tdata = result_bits; one result transfer per input transfer, in order.
// Zero, infinity and NaN pass unchanged; overflow gives signed infinity;
// underflow denormalizes with round-to-nearest-even.
// Pipeline: three register stages (classify + leading-zero count,
// normalize + exponent, round/pack).
// Throughput: one transfer per cycle while the receiver does not stall; the whole pipe advances together.
// When the receiver stalls (tready low with a valid result at the output)
// every stage holds and s_axis_tready drops; nothing is lost or repeated.
// Empty stages hold too during a stall; bubbles do not collapse.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
module double_scale_by_power_of_two
	import dsp2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,	// operand_bits[63:0], scale_exponent[95:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata	// result_bits[63:0]
);
	logic v_s1, v_s2;
	cls_t cls_s1, cls_s2;
	logic [63:0] x_s1, x_s2;
	logic [ManW-1:0] man_s1, man_s2;
	logic [LzW-1:0] lz_s1;
	logic signed [XW-1:0] ex_s1, ex_s2;
	logic en;

	// advance when output slot empty or being taken
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	dsp2_norm u_norm (
		.clk, .arst_n, .en,
		.vin(s_axis_tvalid),
		.x(s_axis_tdata[63:0]),
		.n($signed(s_axis_tdata[95:64])),
		.v_s1, .cls_s1, .x_s1, .man_s1, .lz_s1, .ex_s1
	);

	dsp2_shift u_shift (
		.clk, .arst_n, .en,
		.v_s1, .cls_s1, .x_s1, .man_s1, .lz_s1, .ex_s1,
		.v_s2, .cls_s2, .x_s2, .man_s2, .ex_s2
	);

	dsp2_round u_round (
		.clk, .arst_n, .en,
		.v_s2, .cls_s2, .x_s2, .man_s2, .ex_s2,
		.v_s3(m_axis_tvalid),
		.r_s3(m_axis_tdata)
	);
endmodule

// ----- rtl/dsp2_checker.sv -----
module dsp2_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [95:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("tready not tied to output slot");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
		|=> m_axis_tvalid)
		else $error("result missing after three cycles");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready && s_axis_tdata[62:52] == 11'h7FF
		##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tdata == $past(s_axis_tdata[63:0], 3))
		else $error("NaN or infinity not passed through");
endmodule

bind double_scale_by_power_of_two dsp2_checker u_dsp2_checker (.*);
